// ===== rtl/sobel_pkg.sv =====
// Package with shared types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sobel_pkg;

   // Input item: one raster pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_in_type;

   // Result item: edge magnitude per channel plus markers
   typedef struct packed {
      logic [7:0] edge_red;
      logic [7:0] edge_green;
      logic [7:0] edge_blue;
      logic       run_end;
      logic       frame_end;
   } pixel_out_type;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_ROUND
   } state_type;

   // Register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam int CSR_DATA_WIDTH = 13;
   localparam int FW_WIDTH       = 11;
   localparam int FH_WIDTH       = 13;

   localparam logic [FW_WIDTH-1:0] FW_RESET = 11'd640;
   localparam logic [FH_WIDTH-1:0] FH_RESET = 13'd480;

   // Root unit: 22-bit radicand, two bits per step
   localparam int            SQ_WIDTH   = 22;
   localparam int            ROOT_WIDTH = 11;
   localparam int            REM_WIDTH  = 12;
   localparam logic [3:0]    ROOT_STEPS = 4'd11;
   localparam logic [7:0]    MAG_CLAMP  = 8'd255;

endpackage

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude filter on RGB pixels.
`timescale 1ns / 1ps

// Takes RGB pixels of a frame in raster order and returns, per channel, the
// rounded Sobel gradient magnitude clamped to 255, with neighbors outside the
// frame taken as zero. Output pixel (r-1,c-1) leaves when input (r,c) arrives;
// row ends and the last row give extra results, up to four per input item.
// The two previous rows sit in two MAX_WIDTH x 24 RAMs; they need no clearing
// after reset. An item passes accept, RAM read and window update; each result
// it causes passes gradient, square, 11 steps of the shared two-bits-per-step
// root unit and round, which waits for room in the output register. A finished
// result waits there while the next item is accepted. The user must write
// frame_width and frame_height only while idle; the block does not enforce it.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sobel_pkg::pixel_in_type              req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sobel_pkg::pixel_out_type             rsp_data,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [sobel_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   sobel_pkg::state_type state_ff, state_in;

   logic [sobel_pkg::FW_WIDTH-1:0] fw_ff;
   logic [sobel_pkg::FH_WIDTH-1:0] fh_ff;
   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [23:0]    pix_ff;
   logic [23:0]    win_ff [3][3];
   logic [3:0]     mask_ff;
   logic [3:0]     step_ff;
   logic           run_end_ff, frame_end_ff;
   logic signed [10:0] gx_ff [3];
   logic signed [10:0] gy_ff [3];
   logic [sobel_pkg::SQ_WIDTH-1:0]   sq_ff   [3];
   logic [sobel_pkg::ROOT_WIDTH-1:0] root_ff [3];
   logic [sobel_pkg::REM_WIDTH-1:0]  rem_ff  [3];
   logic           rsp_valid_ff;
   sobel_pkg::pixel_out_type rsp_data_ff;

   logic           accept, rd_en, wr_en, out_load;
   logic [23:0]    old_rd, new_rd, up1, up2;
   logic [CW-1:0]  last_col;
   logic [RW-1:0]  last_row;
   logic           row_last, frame_last_row;
   logic [1:0]     sel_idx;
   logic [3:0]     sel_bit;
   logic [7:0]     p [3][3][3];
   logic [7:0]     mag [3];

   // effective frame size, saturated to 1..MAX
   always_comb begin
      if (fw_ff == '0) begin
         last_col = '0;
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(fw_ff - 11'd1);
      end
      if (fh_ff == '0) begin
         last_row = '0;
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         last_row = RW'(MAX_HEIGHT - 1);
      end else begin
         last_row = RW'(fh_ff - 13'd1);
      end
   end

   assign row_last       = (col_ff >= last_col);
   assign frame_last_row = (row_ff >= last_row);

   // row stores: older holds row r-2, newer row r-1
   sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .ADDR_WIDTH(CW)) u_older (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(col_ff),
      .wr_data(new_rd),
      .rd_en  (rd_en),
      .rd_addr(col_ff),
      .rd_data(old_rd)
   );

   sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .ADDR_WIDTH(CW)) u_newer (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(col_ff),
      .wr_data(pix_ff),
      .rd_en  (rd_en),
      .rd_addr(col_ff),
      .rd_data(new_rd)
   );

   // rows above the frame read as zero
   assign up2 = (row_ff < RW'(2)) ? 24'd0 : old_rd;
   assign up1 = (row_ff == '0) ? 24'd0 : new_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sobel_pkg::ST_IDLE:   if (req_valid) state_in = sobel_pkg::ST_READ;
         sobel_pkg::ST_READ:   state_in = sobel_pkg::ST_SHIFT;
         sobel_pkg::ST_SHIFT: begin
            if ((row_ff != '0 || frame_last_row) && (col_ff != '0 || row_last)) begin
               state_in = sobel_pkg::ST_GRAD;
            end else begin
               state_in = sobel_pkg::ST_IDLE;
            end
         end
         sobel_pkg::ST_GRAD:   state_in = sobel_pkg::ST_SQUARE;
         sobel_pkg::ST_SQUARE: state_in = sobel_pkg::ST_ROOT;
         sobel_pkg::ST_ROOT: begin
            if (step_ff == sobel_pkg::ROOT_STEPS - 4'd1) state_in = sobel_pkg::ST_ROUND;
         end
         sobel_pkg::ST_ROUND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = (mask_ff != '0) ? sobel_pkg::ST_GRAD : sobel_pkg::ST_IDLE;
            end
         end
         default: state_in = sobel_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = (state_ff == sobel_pkg::ST_IDLE);
      accept    = req_ready && req_valid;
      rd_en     = accept;
      wr_en     = (state_ff == sobel_pkg::ST_SHIFT);
      out_load  = (state_ff == sobel_pkg::ST_ROUND) && (!rsp_valid_ff || rsp_ready);
   end

   // pick the earliest pending result: bit0 (0,0) bit1 (0,1) bit2 (1,0) bit3 (1,1)
   always_comb begin
      sel_idx = 2'd3;
      if (mask_ff[2]) sel_idx = 2'd2;
      if (mask_ff[1]) sel_idx = 2'd1;
      if (mask_ff[0]) sel_idx = 2'd0;
      sel_bit = 4'b0001 << sel_idx;
   end

   // window shifted by the selected offset, zero beyond its edge
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (i + int'(sel_idx[1]) < 3 && j + int'(sel_idx[0]) < 3) begin
                  p[ch][i][j] = win_ff[i + int'(sel_idx[1])][j + int'(sel_idx[0])]
                                [(2 - ch) * 8 +: 8];
               end else begin
                  p[ch][i][j] = 8'd0;
               end
            end
         end
      end
   end

   // rounding and clamp of the finished roots
   always_comb begin
      logic [sobel_pkg::ROOT_WIDTH:0] k;
      for (int ch = 0; ch < 3; ch++) begin
         k = {1'b0, root_ff[ch]} + ((rem_ff[ch] > {1'b0, root_ff[ch]}) ? 12'd1 : 12'd0);
         mag[ch] = (k > 12'd255) ? sobel_pkg::MAG_CLAMP : k[7:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sobel_pkg::ST_IDLE;
         fw_ff        <= sobel_pkg::FW_RESET;
         fh_ff        <= sobel_pkg::FH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         mask_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               sobel_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[sobel_pkg::FW_WIDTH-1:0];
               sobel_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
               default: ;
            endcase
         end
         // window update, pending results and raster position
         if (wr_en) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= (col_ff == '0) ? 24'd0 : win_ff[i][1];
               win_ff[i][1] <= (col_ff == '0) ? 24'd0 : win_ff[i][2];
            end
            win_ff[0][2] <= up2;
            win_ff[1][2] <= up1;
            win_ff[2][2] <= pix_ff;
            mask_ff <= {frame_last_row && row_last, frame_last_row && col_ff != '0,
                        row_ff != '0 && row_last, row_ff != '0 && col_ff != '0};
            if (row_last) begin
               col_ff <= '0;
               row_ff <= frame_last_row ? '0 : row_ff + RW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         if (state_ff == sobel_pkg::ST_GRAD) begin
            mask_ff <= mask_ff & ~sel_bit;
         end
         // root step counter
         if (state_ff == sobel_pkg::ST_ROOT) begin
            step_ff <= step_ff + 4'd1;
         end else begin
            step_ff <= '0;
         end
         // output register
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic [9:0] a, b;
      logic signed [21:0] sqx, sqy;
      logic [sobel_pkg::REM_WIDTH+1:0] rsh, trial;
      if (accept) begin
         pix_ff <= {req_data.red, req_data.green, req_data.blue};
      end
      case (state_ff)
         // Sobel X and Y per channel
         sobel_pkg::ST_GRAD: begin
            for (int ch = 0; ch < 3; ch++) begin
               a = 10'(p[ch][0][2]) + {1'b0, p[ch][1][2], 1'b0} + 10'(p[ch][2][2]);
               b = 10'(p[ch][0][0]) + {1'b0, p[ch][1][0], 1'b0} + 10'(p[ch][2][0]);
               gx_ff[ch] <= $signed({1'b0, a}) - $signed({1'b0, b});
               a = 10'(p[ch][2][0]) + {1'b0, p[ch][2][1], 1'b0} + 10'(p[ch][2][2]);
               b = 10'(p[ch][0][0]) + {1'b0, p[ch][0][1], 1'b0} + 10'(p[ch][0][2]);
               gy_ff[ch] <= $signed({1'b0, a}) - $signed({1'b0, b});
            end
            run_end_ff   <= ((mask_ff & ~sel_bit) == '0);
            frame_end_ff <= (sel_idx == 2'd3);
         end
         // sum of squares, root unit cleared
         sobel_pkg::ST_SQUARE: begin
            for (int ch = 0; ch < 3; ch++) begin
               sqx = gx_ff[ch] * gx_ff[ch];
               sqy = gy_ff[ch] * gy_ff[ch];
               sq_ff[ch]   <= 22'(sqx) + 22'(sqy);
               root_ff[ch] <= '0;
               rem_ff[ch]  <= '0;
            end
         end
         // one restoring root step: two radicand bits in, one root bit out
         sobel_pkg::ST_ROOT: begin
            for (int ch = 0; ch < 3; ch++) begin
               rsh   = {rem_ff[ch], sq_ff[ch][sobel_pkg::SQ_WIDTH-1 -: 2]};
               trial = {1'b0, root_ff[ch], 2'b01};
               if (rsh >= trial) begin
                  rem_ff[ch]  <= sobel_pkg::REM_WIDTH'(rsh - trial);
                  root_ff[ch] <= {root_ff[ch][sobel_pkg::ROOT_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff[ch]  <= sobel_pkg::REM_WIDTH'(rsh);
                  root_ff[ch] <= {root_ff[ch][sobel_pkg::ROOT_WIDTH-2:0], 1'b0};
               end
               sq_ff[ch] <= {sq_ff[ch][sobel_pkg::SQ_WIDTH-3:0], 2'b00};
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_data_ff.edge_red   <= mag[0];
         rsp_data_ff.edge_green <= mag[1];
         rsp_data_ff.edge_blue  <= mag[2];
         rsp_data_ff.run_end    <= run_end_ff;
         rsp_data_ff.frame_end  <= frame_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no result left pending once the sequencer is back to idle
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sobel_pkg::ST_IDLE) |-> (mask_ff == '0))
      else $error("pending results left at idle");

   // an accepted item goes straight to the RAM read
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sobel_pkg::ST_READ))
      else $error("accepted item did not start a read");

   // root step count stays in range
   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sobel_pkg::ST_ROOT) |-> (step_ff < sobel_pkg::ROOT_STEPS))
      else $error("root step counter overran");

   // the frame's final result always closes its item
   a_frame_end_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> rsp_data.run_end)
      else $error("frame end without run end");

endmodule

// ===== rtl/sobel_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sobel_ram #(
   parameter int WIDTH      = 24,
   parameter int DEPTH      = 1024,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
